FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the assertion module in src/vtcc_checker.sv.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: src/vtcc_pkg.sv
// ---------------------------------------------------------------------------
// vtcc_pkg
// Constants, types and helpers for the threshold code converter.
// ---------------------------------------------------------------------------
package vtcc_pkg;

  // Voltage word width.
  localparam int VOLTAGE_BITS = 13;
  localparam int CODE_W       = 8;
  localparam int STATUS_W     = 2;

  // Calibration points and limits.
  localparam int MV_LOW_POINT = 1860;
  localparam int MV_SPAN      = 1120;
  localparam int CODE_MAX     = 99;
  localparam int VOLT_MAX     = 2 ** VOLTAGE_BITS - 1;

  // Datapath widths.
  localparam int VD_W    = VOLTAGE_BITS + 1;   // signed voltage offset
  localparam int DIFF_W  = CODE_W + 1;         // signed code difference
  localparam int NUM_W   = VOLTAGE_BITS + 10;  // signed numerator
  localparam int MAG_W   = NUM_W - 1;
  localparam int DEN_W   = 11;                 // holds 1120 and |diff|
  localparam int DIVS_W  = DEN_W + 1;          // doubled denominator
  localparam int DIV_STAGES = 4;
  localparam int DIVD_W  = ((NUM_W + 1 + DIV_STAGES - 1) / DIV_STAGES) * DIV_STAGES;
  localparam int DIV_STEPS  = DIVD_W / DIV_STAGES;

  // Stream word widths.
  localparam int IN_DATA_W  = ((VOLTAGE_BITS + CODE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CODE_W + VOLTAGE_BITS + STATUS_W + 7) / 8) * 8;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CAL_EQUAL = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_CAL_LOW  = 1'b0,
    CFG_CAL_HIGH = 1'b1
  } cfg_idx_e;

  // Word moving through the divider stages.
  typedef struct packed {
    logic              func;
    logic              eq;
    logic              neg;
    logic              negsat;
    logic [DIVD_W-1:0] dq;     // dividend bits shifting out, quotient in
    logic [DIVS_W-1:0] den2;
    logic [DIVS_W-1:0] rem;
  } div_pay_t;

  // Decode a BCD byte as 10 * high nibble + low nibble.
  function automatic logic [CODE_W-1:0] bcd_value(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] hi;
    hi = {4'b0, c[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0, c[3:0]};
  endfunction

endpackage

FILE: src/vtcc_div_stage.sv
// ---------------------------------------------------------------------------
// vtcc_div_stage
// One registered slice of the restoring divider, a few quotient bits deep.
// ---------------------------------------------------------------------------
module vtcc_div_stage import vtcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  div_pay_t pay_i,
  output logic     valid_o,
  input  logic     ready_i,
  output div_pay_t pay_o
);

  logic              v_q;
  div_pay_t          pay_q, pay_d;
  logic              en;
  logic [DIVS_W:0]   rs;

  // The slot can take a word when it is empty or its word moves on.
  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign pay_o   = pay_q;

  // Shift-subtract steps, one quotient bit each.
  always_comb begin
    pay_d = pay_i;
    rs    = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rs       = {pay_d.rem, pay_d.dq[DIVD_W-1]};
      pay_d.dq = pay_d.dq << 1;
      if (rs >= {1'b0, pay_d.den2}) begin
        pay_d.rem   = DIVS_W'(rs - {1'b0, pay_d.den2});
        pay_d.dq[0] = 1'b1;
      end else begin
        pay_d.rem   = rs[DIVS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      pay_q <= pay_d;
    end
  end

endmodule

FILE: src/vmon_threshold_code_converter.sv
// ---------------------------------------------------------------------------
// vmon_threshold_code_converter
// Two-point BCD calibration: millivolts to threshold code and back.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle; the four divider slices of six quotient
// bits each, plus decode, multiply, prepare and output stages, all advance
// independently, and each stage holds its word under back-pressure.
// Reset: empties the pipeline and loads the calibration codes 0x00 and 0x99.
module vmon_threshold_code_converter import vtcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_addr_i,
  input  logic [CODE_W-1:0]     cfg_wdata_i,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: target_millivolts, threshold_code, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func
  input  logic                  s_axis_tuser,
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: code_out, millivolts_out, status, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  typedef struct packed {
    logic                     func;
    logic                     eq;
    logic signed [VD_W-1:0]   vd;
    logic signed [DIFF_W-1:0] kd;
    logic signed [DIFF_W-1:0] diff;
    logic [CODE_W-1:0]        c1;
  } dec_t;

  typedef struct packed {
    logic                    func;
    logic                    eq;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } mul_t;

  // Calibration registers.
  logic [CODE_W-1:0] cal_low_q, cal_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_low_q  <= 8'h00;
      cal_high_q <= 8'h99;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_CAL_LOW:  cal_low_q  <= cfg_wdata_i;
        CFG_CAL_HIGH: cal_high_q <= cfg_wdata_i;
        default:      cal_low_q  <= cal_low_q;
      endcase
    end
  end

  // Stage handshake chain.
  logic s1_v_q, s2_v_q, s3_v_q, m_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;
  logic                  div_v   [DIV_STAGES+1];
  logic                  div_rdy [DIV_STAGES+1];
  div_pay_t              div_pay [DIV_STAGES+1];

  assign out_rdy       = !m_v_q || m_axis_tready;
  assign s3_rdy        = !s3_v_q || div_rdy[0];
  assign s2_rdy        = !s2_v_q || s3_rdy;
  assign s1_rdy        = !s1_v_q || s2_rdy;
  assign s_axis_tready = s1_rdy;

  // Stage 1: decode BCD codes and form differences.
  dec_t              s1_d, s1_q;
  logic [CODE_W-1:0] k_dec, c1_dec, c2_dec;

  always_comb begin
    k_dec     = bcd_value(s_axis_tdata[VOLTAGE_BITS +: CODE_W]);
    c1_dec    = bcd_value(cal_low_q);
    c2_dec    = bcd_value(cal_high_q);
    s1_d.func = s_axis_tuser;
    s1_d.eq   = (c1_dec == c2_dec);
    s1_d.vd   = $signed({1'b0, s_axis_tdata[VOLTAGE_BITS-1:0]})
              - $signed(VD_W'(MV_LOW_POINT));
    s1_d.kd   = $signed({1'b0, k_dec}) - $signed({1'b0, c1_dec});
    s1_d.diff = $signed({1'b0, c2_dec}) - $signed({1'b0, c1_dec});
    s1_d.c1   = c1_dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && s_axis_tvalid) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: numerator and positive denominator of the rounded quotient.
  mul_t                           s2_d, s2_q;
  logic signed [VD_W+DIFF_W-1:0]  prod_v;
  logic signed [NUM_W-1:0]        c1_term, p_code;

  always_comb begin
    prod_v    = s1_q.vd * s1_q.diff;
    c1_term   = $signed(NUM_W'(s1_q.c1) * NUM_W'(MV_SPAN));
    p_code    = NUM_W'(s1_q.diff) * $signed(NUM_W'(MV_LOW_POINT))
              + NUM_W'(s1_q.kd) * $signed(NUM_W'(MV_SPAN));
    s2_d.func = s1_q.func;
    s2_d.eq   = s1_q.eq;
    if (!s1_q.func) begin
      s2_d.num = NUM_W'(prod_v) + c1_term;
      s2_d.den = DEN_W'(MV_SPAN);
    end else if (s1_q.diff[DIFF_W-1]) begin
      s2_d.num = -p_code;
      s2_d.den = DEN_W'(-s1_q.diff);
    end else begin
      s2_d.num = p_code;
      s2_d.den = DEN_W'(s1_q.diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  // Stage 3: sign handling and dividend 2*|num| + den over divisor 2*den.
  div_pay_t          s3_d, s3_q;
  logic [MAG_W-1:0]  mag;

  always_comb begin
    mag         = s2_q.num[NUM_W-1] ? MAG_W'(-s2_q.num) : MAG_W'(s2_q.num);
    s3_d.func   = s2_q.func;
    s3_d.eq     = s2_q.eq;
    s3_d.neg    = s2_q.num[NUM_W-1];
    s3_d.negsat = ({1'b0, mag, 1'b0} >= (MAG_W+2)'(s2_q.den));
    s3_d.dq     = s2_q.num[NUM_W-1] ? '0
                : DIVD_W'({mag, 1'b0}) + DIVD_W'(s2_q.den);
    s3_d.den2   = {s2_q.den, 1'b0};
    s3_d.rem    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_v_q) begin
      s3_q <= s3_d;
    end
  end

  // Divider slices.
  assign div_v[0]            = s3_v_q;
  assign div_pay[0]          = s3_q;
  assign div_rdy[DIV_STAGES] = out_rdy;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    vtcc_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_v[g]),
      .ready_o (div_rdy[g]),
      .pay_i   (div_pay[g]),
      .valid_o (div_v[g+1]),
      .ready_i (div_rdy[g+1]),
      .pay_o   (div_pay[g+1])
    );
  end

  // Output stage: saturation, BCD encoding and the output register.
  div_pay_t                fin;
  logic [DIVD_W-1:0]       lim, qc;
  logic                    sat_hi;
  logic [6:0]              code7;
  logic [13:0]             tens_prod;
  logic [3:0]              tens, ones;
  logic [CODE_W-1:0]       code_d;
  logic [VOLTAGE_BITS-1:0] mv_d;
  status_e                 status_d;
  logic [OUT_DATA_W-1:0]   m_data_q;

  always_comb begin
    fin       = div_pay[DIV_STAGES];
    lim       = fin.func ? DIVD_W'(VOLT_MAX) : DIVD_W'(CODE_MAX);
    sat_hi    = (fin.dq > lim);
    qc        = sat_hi ? lim : fin.dq;
    code7     = qc[6:0];
    tens_prod = 14'(code7) * 14'd103;
    tens      = tens_prod[13:10];
    ones      = 4'(code7 - 7'(tens) * 7'd10);
    code_d    = '0;
    mv_d      = '0;
    status_d  = STATUS_OK;
    if (fin.eq) begin
      status_d = STATUS_CAL_EQUAL;
    end else if (fin.neg) begin
      status_d = fin.negsat ? STATUS_SATURATED : STATUS_OK;
    end else begin
      status_d = sat_hi ? STATUS_SATURATED : STATUS_OK;
      if (fin.func) begin
        mv_d = qc[VOLTAGE_BITS-1:0];
      end else begin
        code_d = {tens, ones};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (out_rdy) begin
      m_v_q <= div_v[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && div_v[DIV_STAGES]) begin
      m_data_q <= OUT_DATA_W'({status_d, mv_d, code_d});
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: src/vtcc_checker.sv
// ---------------------------------------------------------------------------
// vtcc_assertions
// Port-level checks on the converter's result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vtcc_assertions import vtcc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [CODE_W-1:0]       code_w;
  logic [VOLTAGE_BITS-1:0] mv_w;
  logic [STATUS_W-1:0]     status_w;

  assign code_w   = m_axis_tdata[CODE_W-1:0];
  assign mv_w     = m_axis_tdata[CODE_W +: VOLTAGE_BITS];
  assign status_w = m_axis_tdata[CODE_W+VOLTAGE_BITS +: STATUS_W];

  // A stalled result word stays in place.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Equal calibration codes give no conversion at all.
  `ASSERT_IMPL(a_cal_eq_zero, clk_i, rst_ni, m_axis_tvalid && status_w == STATUS_CAL_EQUAL, code_w == '0 && mv_w == '0)

  // The code result is a valid BCD byte.
  `ASSERT_IMPL(a_code_bcd, clk_i, rst_ni, m_axis_tvalid, code_w[3:0] <= 4'd9 && code_w[7:4] <= 4'd9)

  // Only one of the two results is used in a word, and status is a known code.
  `ASSERT_IMPL(a_one_result, clk_i, rst_ni, m_axis_tvalid, (code_w == '0 || mv_w == '0) && status_w != 2'd3)

endmodule

bind vmon_threshold_code_converter vtcc_assertions u_vtcc_assertions (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: test/vtcc_checker.sv
// ---------------------------------------------------------------------------
// vtcc_checker
// Watches the configuration port and both streams of the threshold code
// converter. It predicts each result word from its own copy of the
// calibration codes, then compares the output words in order.
// ---------------------------------------------------------------------------
module vtcc_checker import vtcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_addr_i,
  input  logic [CODE_W-1:0]     cfg_wdata_i,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  // tdata: target_millivolts, threshold_code, zero fill
  input  logic [IN_DATA_W-1:0]  s_data_i,
  // tuser: func
  input  logic                  s_user_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  // tdata: code_out, millivolts_out, status, zero fill
  input  logic [OUT_DATA_W-1:0] m_data_i,
  output int                    mismatch_cnt_o,
  output int                    outstanding_o
);

  typedef struct packed {
    logic [CODE_W-1:0]       code;
    logic [VOLTAGE_BITS-1:0] mv;
    status_e                 status;
  } conv_word_t;

  conv_word_t        expected_q[$];
  logic [CODE_W-1:0] cal_lo;
  logic [CODE_W-1:0] cal_hi;
  int                mismatches;

  // A BCD byte counts as ten times its high nibble plus its low nibble,
  // even when a nibble is above nine.
  function automatic longint bcd_decode(input logic [CODE_W-1:0] c);
    return longint'(c[7:4]) * 10 + longint'(c[3:0]);
  endfunction

  // Quotient rounded half away from zero; the divisor is positive.
  function automatic longint div_round(input longint n, input longint d);
    if (n >= 0) begin
      return (2 * n + d) / (2 * d);
    end
    return -((-2 * n + d) / (2 * d));
  endfunction

  function automatic conv_word_t convert(input logic func,
                                         input logic [VOLTAGE_BITS-1:0] mv,
                                         input logic [CODE_W-1:0] code,
                                         input logic [CODE_W-1:0] lo,
                                         input logic [CODE_W-1:0] hi);
    conv_word_t r;
    longint     c1;
    longint     diff;
    longint     num;
    longint     den;
    longint     q;
    r.code   = '0;
    r.mv     = '0;
    r.status = STATUS_OK;
    c1       = bcd_decode(lo);
    diff     = bcd_decode(hi) - c1;
    if (diff == 0) begin
      r.status = STATUS_CAL_EQUAL;
    end else if (!func) begin
      // Millivolts to code, clamped to 0..99 and re-encoded as BCD.
      num = (longint'(mv) - MV_LOW_POINT) * diff + c1 * MV_SPAN;
      q   = div_round(num, MV_SPAN);
      if (q < 0) begin
        q        = 0;
        r.status = STATUS_SATURATED;
      end else if (q > CODE_MAX) begin
        q        = CODE_MAX;
        r.status = STATUS_SATURATED;
      end
      r.code = {4'(q / 10), 4'(q % 10)};
    end else begin
      // Code to millivolts, clamped to the voltage word range.
      num = longint'(MV_LOW_POINT) * diff + (bcd_decode(code) - c1) * MV_SPAN;
      den = diff;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      q = div_round(num, den);
      if (q < 0) begin
        q        = 0;
        r.status = STATUS_SATURATED;
      end else if (q > VOLT_MAX) begin
        q        = VOLT_MAX;
        r.status = STATUS_SATURATED;
      end
      r.mv = VOLTAGE_BITS'(q);
    end
    return r;
  endfunction

  // Track the calibration codes, queue predictions, compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    conv_word_t want;
    conv_word_t got;
    if (!rst_ni) begin
      expected_q.delete();
      cal_lo     = 8'h00;
      cal_hi     = 8'h99;
      mismatches = 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        expected_q.push_back(convert(s_user_i, s_data_i[0 +: VOLTAGE_BITS],
                                     s_data_i[VOLTAGE_BITS +: CODE_W], cal_lo, cal_hi));
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_CAL_LOW:  cal_lo = cfg_wdata_i;
          CFG_CAL_HIGH: cal_hi = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        got.code   = m_data_i[0 +: CODE_W];
        got.mv     = m_data_i[CODE_W +: VOLTAGE_BITS];
        got.status = status_e'(m_data_i[CODE_W + VOLTAGE_BITS +: STATUS_W]);
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got %h", $time, m_data_i);
        end else begin
          want = expected_q.pop_front();
          if (got.code !== want.code) begin
            mismatches++;
            $display("%0t: code_out expected %h, got %h", $time, want.code, got.code);
          end
          if (got.mv !== want.mv) begin
            mismatches++;
            $display("%0t: millivolts_out expected %0d, got %0d", $time, want.mv, got.mv);
          end
          if (got.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          end
        end
      end
    end
    mismatch_cnt_o <= mismatches;
    outstanding_o  <= expected_q.size();
  end

endmodule

FILE: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus for the threshold code converter. A directed set covers the field
// extremes, both directions, saturation, half-way rounding and equal
// calibration codes; then random words run under many calibration settings
// with random idling on both streams. The checker judges every result word.
// ---------------------------------------------------------------------------
module tb import vtcc_pkg::*;;

  localparam int PIPE_LATENCY   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 12;
  localparam int WORDS_PER_PHASE = 75;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [0:0]            cfg_addr      = CFG_CAL_LOW;
  logic [CODE_W-1:0]     cfg_wdata     = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    mismatch_cnt;
  int                    outstanding;
  int                    idle_cycles   = 0;
  bit                    quiet         = 1'b0;

  always #1 clk = ~clk;

  vmon_threshold_code_converter u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  vtcc_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_i      (s_axis_tready),
    .s_data_i       (s_axis_tdata),
    .s_user_i       (s_axis_tuser),
    .m_valid_i      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_data_i       (m_axis_tdata),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  // The receiver stalls now and then, except in a quiet stretch.
  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 6);
  end

  // Give up when no word moves on either stream for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word and hold it until it is taken.
  task automatic send_word(input logic func, input logic [VOLTAGE_BITS-1:0] mv,
                           input logic [CODE_W-1:0] code);
    while (!quiet && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= IN_DATA_W'({code, mv});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Load both calibration codes once the pipeline is empty.
  task automatic program_cal(input logic [CODE_W-1:0] lo, input logic [CODE_W-1:0] hi);
    drain_results();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_CAL_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_addr  <= CFG_CAL_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Half of the codes are valid BCD, the rest any byte.
  function automatic logic [CODE_W-1:0] pick_code();
    if ($urandom_range(1)) begin
      return {4'($urandom_range(9)), 4'($urandom_range(9))};
    end
    return CODE_W'($urandom);
  endfunction

  // Random word: voltages spread over the whole range, the calibrated
  // window, or the corner values.
  task automatic send_random_word();
    logic                    func;
    logic [VOLTAGE_BITS-1:0] mv;
    func = 1'($urandom_range(1));
    case ($urandom_range(3))
      0:       mv = VOLTAGE_BITS'($urandom);
      1, 2:    mv = VOLTAGE_BITS'($urandom_range(3400, 1400));
      default: begin
        case ($urandom_range(3))
          0:       mv = '0;
          1:       mv = VOLTAGE_BITS'(VOLT_MAX);
          2:       mv = VOLTAGE_BITS'(MV_LOW_POINT);
          default: mv = VOLTAGE_BITS'(MV_LOW_POINT + MV_SPAN);
        endcase
      end
    endcase
    send_word(func, mv, pick_code());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset calibration (0x00 and 0x99).
    send_word(1'b0, 13'd0,    8'h00);   // below the code range
    send_word(1'b0, 13'h1FFF, 8'hFF);   // above the code range
    send_word(1'b0, 13'd1860, 8'h00);   // low calibration point
    send_word(1'b0, 13'd2980, 8'h00);   // high calibration point
    send_word(1'b0, 13'd1865, 8'h00);
    send_word(1'b0, 13'd2000, 8'hFF);
    send_word(1'b1, 13'd0,    8'h00);
    send_word(1'b1, 13'h1FFF, 8'h99);
    send_word(1'b1, 13'd0,    8'hFF);   // non-decimal nibbles
    send_word(1'b1, 13'd0,    8'h9A);
    send_word(1'b1, 13'd0,    8'hA0);
    send_word(1'b1, 13'h1FFF, 8'h45);

    // Steep slope: code to voltage saturates high.
    program_cal(8'h00, 8'h01);
    send_word(1'b1, 13'd0,    8'hFF);
    send_word(1'b0, 13'h1FFF, 8'h00);

    // Falling slope: code to voltage saturates low.
    program_cal(8'h99, 8'h98);
    send_word(1'b1, 13'd0,    8'hFF);
    send_word(1'b0, 13'd0,    8'h00);

    // Equal calibration codes.
    program_cal(8'h42, 8'h42);
    send_word(1'b0, 13'd2500, 8'h00);
    send_word(1'b1, 13'd0,    8'h42);

    // One code per 20 mV: exact halves round away from zero.
    program_cal(8'h00, 8'h56);
    send_word(1'b0, 13'd1870, 8'h00);
    send_word(1'b0, 13'd1850, 8'h00);
    send_word(1'b1, 13'd0,    8'h00);

    // Random phases, each under its own calibration.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       program_cal(8'h00, 8'h99);
        1:       program_cal(8'hFF, 8'h00);
        2:       program_cal(8'h00, 8'hFF);
        3:       program_cal(8'h99, 8'h00);
        4:       program_cal(8'hFF, 8'hFF);
        default: program_cal(pick_code(), pick_code());
      endcase
      quiet = (p == 2);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (p == 5 && n == WORDS_PER_PHASE / 2) begin
          drain_results();
        end
        send_random_word();
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
